### hdl/sfp_pkg.sv
// sfp_pkg: shared constants, types and register indexes for the sensor record
// field parser. No dependencies.

package sfp_pkg;

  localparam int FIELD_COUNT     = 9;
  localparam int MAX_FIELD_BYTES = 10;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 4;
  localparam int MAG_W   = 27;
  localparam int VALUE_W = 28;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FIELD_COUNT - 1);
  localparam logic [COUNT_W-1:0] BYTE_LIMIT = COUNT_W'(MAX_FIELD_BYTES - 1);
  localparam logic [MAG_W-1:0]   MAG_MAX    = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0]   MAG_SAFE   = MAG_W'(((2**MAG_W - 1) - 9) / 10);

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd91;
  localparam logic [BYTE_W-1:0] DELIM_BYTE_RESET = 8'd44;

  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;

  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_DELIM_BYTE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        field_index;
    logic signed [VALUE_W-1:0] field_value;
    logic                      field_ok;
    logic                      record_end;
  } result_t;

endpackage

### hdl/sfp_parse_core.sv
// sfp_parse_core: per-byte record and field state with the decimal parse
// datapath. Depends on sfp_pkg.

module sfp_parse_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [sfp_pkg::BYTE_W-1:0] rx_data,
  input  logic [sfp_pkg::BYTE_W-1:0] start_byte,
  input  logic [sfp_pkg::BYTE_W-1:0] delim_byte,
  output logic                       res_valid,
  output sfp_pkg::result_t           res
);
  import sfp_pkg::*;

  logic               in_record, in_record_next;
  logic [INDEX_W-1:0] field_position, field_position_next;
  logic [COUNT_W-1:0] bytes_in_field, bytes_in_field_next;
  phase_t             number_phase, number_phase_next;
  logic               is_negative, is_negative_next;
  logic [MAG_W-1:0]   magnitude, magnitude_next;

  logic               is_digit;
  logic               is_space;
  logic [MAG_W-1:0]   mag_digit;
  logic [COUNT_W-1:0] count_inc;
  logic               last_field;
  logic [VALUE_W-1:0] mag_ext;

  assign is_digit   = (rx_data >= CHAR_ZERO) && (rx_data <= CHAR_NINE);
  assign is_space   = (rx_data == CHAR_SPACE) || ((rx_data >= CHAR_TAB) && (rx_data <= CHAR_CR));
  assign mag_digit  = (magnitude > MAG_SAFE) ? MAG_MAX :
                      (magnitude << 3) + (magnitude << 1) + MAG_W'(rx_data - CHAR_ZERO);
  assign count_inc  = bytes_in_field + COUNT_W'(1);
  assign last_field = field_position >= LAST_INDEX;
  assign mag_ext    = {1'b0, magnitude};

  always_comb begin
    in_record_next      = in_record;
    field_position_next = field_position;
    bytes_in_field_next = bytes_in_field;
    number_phase_next   = number_phase;
    is_negative_next    = is_negative;
    magnitude_next      = magnitude;
    res_valid           = 1'b0;
    res.field_index     = field_position;
    res.field_value     = is_negative ? -$signed(mag_ext) : $signed(mag_ext);
    res.field_ok        = 1'b1;
    res.record_end      = last_field;

    if (!in_record) begin
      if (rx_data == start_byte) begin
        in_record_next      = 1'b1;
        field_position_next = '0;
        bytes_in_field_next = '0;
        number_phase_next   = PH_SKIP;
        is_negative_next    = 1'b0;
        magnitude_next      = '0;
      end
    end else begin
      if (rx_data != delim_byte) begin
        unique case (number_phase)
          PH_SKIP: begin
            if (is_space) begin
              number_phase_next = PH_SKIP;
            end else if (rx_data == CHAR_PLUS || rx_data == CHAR_MINUS) begin
              is_negative_next  = (rx_data == CHAR_MINUS);
              number_phase_next = PH_DIGITS;
            end else if (is_digit) begin
              magnitude_next    = mag_digit;
              number_phase_next = PH_DIGITS;
            end else begin
              number_phase_next = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              magnitude_next = mag_digit;
            end else begin
              number_phase_next = PH_DONE;
            end
          end
          default: begin
            number_phase_next = number_phase;
          end
        endcase
        bytes_in_field_next = count_inc;
      end

      if (rx_data == delim_byte || count_inc >= BYTE_LIMIT) begin
        res_valid = 1'b1;
        if (rx_data != delim_byte) begin
          res.field_ok    = 1'b0;
          res.field_value = '0;
        end
        bytes_in_field_next = '0;
        number_phase_next   = PH_SKIP;
        is_negative_next    = 1'b0;
        magnitude_next      = '0;
        if (last_field) begin
          in_record_next      = 1'b0;
          field_position_next = '0;
        end else begin
          field_position_next = field_position + INDEX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_record      <= 1'b0;
      field_position <= '0;
      bytes_in_field <= '0;
      number_phase   <= PH_SKIP;
      is_negative    <= 1'b0;
      magnitude      <= '0;
    end else if (take) begin
      in_record      <= in_record_next;
      field_position <= field_position_next;
      bytes_in_field <= bytes_in_field_next;
      number_phase   <= number_phase_next;
      is_negative    <= is_negative_next;
      magnitude      <= magnitude_next;
    end
  end

endmodule

### hdl/sfp_out_reg.sv
// sfp_out_reg: result register holding one finished field until the
// downstream side takes it. Depends on sfp_pkg.

module sfp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfp_pkg::result_t res,
  input  logic             field_ready,
  output logic             field_valid,
  output sfp_pkg::result_t held
);
  import sfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_valid <= 1'b0;
    end else if (load) begin
      field_valid <= 1'b1;
    end else if (field_ready) begin
      field_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

### hdl/sensor_record_field_parser.sv
// sensor_record_field_parser: top level with configuration registers, byte
// input register, parse core and result register. Depends on sfp_pkg,
// sfp_parse_core and sfp_out_reg.
//
// Takes one byte per cycle on rx_valid/rx_ready while no result is stalled.
// Bytes before the start byte are dropped; within a record each field ends on
// the delimiter byte or when MAX_FIELD_BYTES-1 bytes arrive without one, and a
// transaction on field_valid/field_ready then reports its index, atoi value,
// ok flag and record-end mark. A byte sits in the input register after it is
// accepted, and its result is loaded into the result register, raising
// field_valid, when the byte advances into the parse core; the byte waits
// there while an earlier result is stalled. Sustained rate is one byte per
// cycle while field_ready stays high, set by the state update (multiply by ten
// and add) in the parse core. Backpressure on field_ready stalls byte intake
// only while a result is waiting. Write start_byte (index 0) and delim_byte
// (index 1) only while idle.

module sensor_record_field_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [sfp_pkg::BYTE_W-1:0]         cfg_data,
  input  logic                               rx_valid,
  output logic                               rx_ready,
  input  logic [sfp_pkg::BYTE_W-1:0]         rx_byte,
  output logic                               field_valid,
  input  logic                               field_ready,
  output logic [sfp_pkg::INDEX_W-1:0]        field_index,
  output logic signed [sfp_pkg::VALUE_W-1:0] field_value,
  output logic                               field_ok,
  output logic                               record_end
);
  import sfp_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] delim_byte;
  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              advance;
  logic              res_valid;
  result_t           res;
  result_t           held;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      delim_byte <= DELIM_BYTE_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_START_BYTE: start_byte <= cfg_data;
        REG_DELIM_BYTE: delim_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = hold_valid && (!field_valid || field_ready);
  assign rx_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_ready) begin
      hold_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      hold_byte <= rx_byte;
    end
  end

  sfp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (advance),
    .rx_data    (hold_byte),
    .start_byte (start_byte),
    .delim_byte (delim_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfp_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && res_valid),
    .res         (res),
    .field_ready (field_ready),
    .field_valid (field_valid),
    .held        (held)
  );

  assign field_index = held.field_index;
  assign field_value = held.field_value;
  assign field_ok    = held.field_ok;
  assign record_end  = held.record_end;

endmodule

### hdl/sfp_checker.sv
// sfp_checker: port-level assertions for the sensor record field parser,
// bound to the top level. Depends on sfp_pkg and sensor_record_field_parser.

module sfp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               field_valid,
  input logic                               field_ready,
  input logic [sfp_pkg::INDEX_W-1:0]        field_index,
  input logic signed [sfp_pkg::VALUE_W-1:0] field_value,
  input logic                               field_ok,
  input logic                               record_end
);
  import sfp_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    field_valid && !field_ready |=> field_valid && $stable(field_index) &&
    $stable(field_value) && $stable(field_ok) && $stable(record_end))
    else $error("result changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !field_valid)
    else $error("result right after reset");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    field_valid |-> field_index <= LAST_INDEX)
    else $error("field index past last field");

  a_record_end: assert property (@(posedge clk) disable iff (rst)
    field_valid |-> (record_end == (field_index == LAST_INDEX)))
    else $error("record end mark on wrong field");

  a_dropped_zero: assert property (@(posedge clk) disable iff (rst)
    field_valid && !field_ok |-> field_value == '0)
    else $error("dropped field with nonzero value");

endmodule

bind sensor_record_field_parser sfp_checker u_sfp_checker (
  .clk         (clk),
  .rst         (rst),
  .field_valid (field_valid),
  .field_ready (field_ready),
  .field_index (field_index),
  .field_value (field_value),
  .field_ok    (field_ok),
  .record_end  (record_end)
);
